// File: rtl/core/pcst_pkg.sv
package pcst_pkg;

    // Item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_LOAD = 2'd1;
    localparam logic [1:0] KIND_GATE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SPEAKER_MUTE = 1'b0;
    localparam logic CFG_TICK_RATE    = 1'b1;

    // Field and state widths
    localparam int unsigned DIVISOR_W = 16;
    localparam int unsigned RATE_W    = 20;
    localparam int unsigned COUNT_W   = 24;

    // Divider operand width: holds the timer clock, the tick rate and a frequency
    localparam int unsigned DIV_W   = 21;
    localparam int unsigned DCNT_W  = 5;

    localparam logic [DIV_W-1:0]   PIT_CLOCK_HZ = 21'd1193180;
    localparam logic [RATE_W-1:0]  TICK_RATE_RST = 20'd32000;

    // Control from the sequencer to the wave generator
    typedef struct packed {
        logic                 tick;
        logic                 gate_set;
        logic                 gate_en;
        logic                 hp_load;
        logic [COUNT_W-1:0]   hp_value;
        logic                 mute;
    } wave_ctrl_t;

    // Wave generator status for the current transaction
    typedef struct packed {
        logic level_next;
        logic strobe;
    } wave_stat_t;

endpackage

// File: rtl/core/pcst_div.sv
// Restoring divider, one quotient bit per cycle
module pcst_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcst_pkg::DIV_W-1:0]  dividend,
    input  logic [pcst_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [pcst_pkg::DIV_W-1:0]  quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [pcst_pkg::DCNT_W-1:0]  cnt_reg;
    logic [pcst_pkg::DIV_W-1:0]   q_reg;
    logic [pcst_pkg::DIV_W-1:0]   r_reg;
    logic [pcst_pkg::DIV_W-1:0]   d_reg;

    logic [pcst_pkg::DIV_W:0]     r_shift;
    logic [pcst_pkg::DIV_W:0]     r_diff;
    logic                         r_ge;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        r_shift = {r_reg, q_reg[pcst_pkg::DIV_W-1]};
        r_diff  = r_shift - {1'b0, d_reg};
        r_ge    = ~r_diff[pcst_pkg::DIV_W];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pcst_pkg::DCNT_W'(pcst_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[pcst_pkg::DIV_W-2:0], r_ge};
            r_reg <= r_ge ? r_diff[pcst_pkg::DIV_W-1:0] : r_shift[pcst_pkg::DIV_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/pcst_wave.sv
// Tick counter, gate and square wave level
module pcst_wave
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcst_pkg::wave_ctrl_t    ctrl,
    output pcst_pkg::wave_stat_t    stat
);

    logic [pcst_pkg::COUNT_W-1:0] count_reg;
    logic [pcst_pkg::COUNT_W-1:0] count_next;
    logic [pcst_pkg::COUNT_W-1:0] half_reg;
    logic                         level_reg;
    logic                         level_next;
    logic                         gated_reg;
    logic [pcst_pkg::COUNT_W-1:0] count_inc;
    logic                         toggle;

    // Gated tick: increment, compare against the half-period
    always_comb
    begin
        count_inc  = count_reg + 1'b1;
        toggle     = ctrl.tick && gated_reg && (count_inc >= half_reg);
        count_next = count_reg;
        level_next = level_reg;
        if (ctrl.tick && gated_reg)
        begin
            count_next = toggle ? '0 : count_inc;
            level_next = level_reg ^ toggle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            half_reg  <= '0;
            level_reg <= 1'b0;
            gated_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
            if (ctrl.gate_set)
            begin
                gated_reg <= ctrl.gate_en;
            end
            if (ctrl.hp_load)
            begin
                half_reg <= ctrl.hp_value;
            end
        end
    end

    assign stat.level_next = level_next;
    assign stat.strobe     = toggle & ~ctrl.mute;

endmodule

// File: rtl/core/pc_speaker_tone_generator.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  kind[1:0], divisor[15:0], gate_enable
// out       output     out_valid / out_stall level, drive_strobe
// cfg       input      cfg_valid / cfg_ready cfg_index (0 mute, 1 tick rate), cfg_data[19:0]
//
// Every transaction yields one result, registered at the edge that accepts it.
// Tick and gate transactions end at that edge. A divisor load then runs up to two
// 21-step bit-serial divisions (timer clock / divisor, then tick rate / frequency)
// on one shared divider, the second only for a nonzero frequency; input stalls meanwhile.
// Reset clears the state; no clearing pass. Input stalls while the result
// register is full and out_stall is high.
module pc_speaker_tone_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          kind,
    input  logic [pcst_pkg::DIVISOR_W-1:0]      divisor,
    input  logic                                gate_enable,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                level,
    output logic                                drive_strobe,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [pcst_pkg::RATE_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREQ,
        S_HALF
    } state_t;

    state_t                        state_reg;
    logic                          mute_reg;
    logic [pcst_pkg::RATE_W-1:0]   rate_reg;
    logic                          out_valid_reg;
    logic                          level_reg;
    logic                          strobe_reg;

    logic                          in_acc;
    logic                          div_start;
    logic [pcst_pkg::DIV_W-1:0]    div_dividend;
    logic [pcst_pkg::DIV_W-1:0]    div_divisor;
    logic                          div_done;
    logic [pcst_pkg::DIV_W-1:0]    div_q;

    pcst_pkg::wave_ctrl_t          wctrl;
    pcst_pkg::wave_stat_t          wstat;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    // Register writes only with no transaction offered, running or waiting
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg && !in_valid;

    // Divider launch: first frequency, then half-period count
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = pcst_pkg::PIT_CLOCK_HZ;
        div_divisor  = {{(pcst_pkg::DIV_W - pcst_pkg::DIVISOR_W){1'b0}}, divisor};
        if (in_acc && (kind == pcst_pkg::KIND_LOAD) && (divisor != '0))
        begin
            div_start = 1'b1;
        end
        else if ((state_reg == S_FREQ) && div_done && (div_q != '0))
        begin
            div_start    = 1'b1;
            div_dividend = {{(pcst_pkg::DIV_W - pcst_pkg::RATE_W){1'b0}}, rate_reg};
            div_divisor  = div_q;
        end
    end

    // Wave generator control
    always_comb
    begin
        wctrl.tick     = in_acc && (kind == pcst_pkg::KIND_TICK);
        wctrl.gate_set = in_acc && (kind == pcst_pkg::KIND_GATE);
        wctrl.gate_en  = gate_enable;
        wctrl.mute     = mute_reg;
        wctrl.hp_load  = 1'b0;
        wctrl.hp_value = '0;
        if (in_acc && (kind == pcst_pkg::KIND_LOAD) && (divisor == '0))
        begin
            wctrl.hp_load = 1'b1;
        end
        else if ((state_reg == S_FREQ) && div_done && (div_q == '0))
        begin
            wctrl.hp_load = 1'b1;
        end
        else if ((state_reg == S_HALF) && div_done)
        begin
            wctrl.hp_load  = 1'b1;
            wctrl.hp_value = {{(pcst_pkg::COUNT_W - pcst_pkg::DIV_W + 1){1'b0}},
                              div_q[pcst_pkg::DIV_W-1:1]};
        end
    end

    pcst_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    pcst_wave u_wave
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (wctrl),
        .stat  (wstat)
    );

    // Sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mute_reg      <= 1'b0;
            rate_reg      <= pcst_pkg::TICK_RATE_RST;
            out_valid_reg <= 1'b0;
            level_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pcst_pkg::CFG_SPEAKER_MUTE: mute_reg <= cfg_data[0];
                    pcst_pkg::CFG_TICK_RATE:    rate_reg <= cfg_data;
                    default:                    mute_reg <= mute_reg;
                endcase
            end

            if (in_acc)
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= wstat.level_next;
                strobe_reg    <= wstat.strobe;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (div_start)
                    begin
                        state_reg <= S_FREQ;
                    end
                end
                S_FREQ:
                begin
                    if (div_done)
                    begin
                        state_reg <= div_start ? S_HALF : S_IDLE;
                    end
                end
                S_HALF:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign level        = level_reg;
    assign drive_strobe = strobe_reg;

endmodule
